// File: hw/rtl/lhec_pkg.sv
// package: constants, payload words, control structs and states of the layer hit classifier
`timescale 1ns / 1ps
`default_nettype none

package lhec_pkg;

    localparam int NUM_LAYERS  = 16;
    localparam int COUNT_BITS  = 12;
    localparam int LAYER_W     = 4;
    localparam int CFG_W       = 12;
    localparam int TOTAL_W     = 32;
    localparam int LAYER_IDX_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int LAYERS_W    = $clog2(NUM_LAYERS + 1);
    localparam int PROD_W      = (COUNT_BITS + 4 > CFG_W + LAYERS_W) ?
                                 (COUNT_BITS + 4) : (CFG_W + LAYERS_W);
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_CUT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MAX_CUT = 1'd1;

    localparam logic [CFG_W-1:0] DENSITY_CUT_RESET    = 12'd48;
    localparam logic [CFG_W-1:0] SECOND_MAX_CUT_RESET = 12'd10;

    typedef struct packed {
        logic [LAYER_W-1:0] hit_layer;
        logic               hit_present;
        logic               last_of_event;
    } hit_word_t;

    typedef struct packed {
        logic                  is_mip;
        logic [COUNT_BITS-1:0] hit_count;
        logic [LAYERS_W-1:0]   layers_hit;
        logic [COUNT_BITS-1:0] first_max;
        logic [COUNT_BITS-1:0] second_max;
        logic [TOTAL_W-1:0]    class_event_number;
    } result_word_t;

    typedef struct packed {
        logic [LAYER_IDX_W-1:0] addr;
        logic                   inc;
        logic                   wipe;
        logic                   hits_clr;
    } hist_ctrl_t;

    typedef struct packed {
        logic clear;
        logic step;
    } rank_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DECIDE,
        ST_FINISH
    } lhec_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/lhec_hit_if.sv
// interface: input hit word channel
`timescale 1ns / 1ps
`default_nettype none

interface lhec_hit_if;
    import lhec_pkg::*;

    logic      valid;
    logic      ready;
    hit_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/lhec_result_if.sv
// interface: event result word channel
`timescale 1ns / 1ps
`default_nettype none

interface lhec_result_if;
    import lhec_pkg::*;

    logic         valid;
    logic         ready;
    result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/layer_hit_event_classifier_core.sv
// top level: sequencer, cut registers, class totals and result register
`timescale 1ns / 1ps
`default_nettype none

// Hits enter one word per cycle while idle; each word with a valid layer bumps
// that layer's count and the event hit count at the edge it is taken. The word
// closing an event starts a walk over the NUM_LAYERS per-layer counts through one
// shared compare unit, one layer per cycle, clearing each count as it is read; a
// decide state does the density multiply and compare; a finish state loads the
// result register. Input stalls from the closing word to that load, which waits
// while a previous result is unread. Hit words are taken while a result waits.
// Cut registers must be written only when idle; the core does not enforce it.

module layer_hit_event_classifier_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    lhec_hit_if.sink                            hit_in,
    lhec_result_if.source                       result_out,
    input  wire logic                           cfg_we,
    input  wire logic [lhec_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lhec_pkg::CFG_W-1:0]     cfg_data
);
    import lhec_pkg::*;

    lhec_state_t state_reg, state_next;

    logic [CFG_W-1:0]       density_cut_reg;
    logic [CFG_W-1:0]       second_max_cut_reg;
    logic [LAYER_IDX_W-1:0] walk_idx_reg, walk_idx_next;
    logic                   mip_reg, mip_next;
    logic [TOTAL_W-1:0]     mip_total_reg, shower_total_reg;
    logic                   out_valid_reg;
    result_word_t           out_data_reg;

    hist_ctrl_t             hist_ctrl;
    rank_ctrl_t             rank_ctrl;
    logic [COUNT_BITS-1:0]  rd_count;
    logic [COUNT_BITS-1:0]  event_hits;
    logic [LAYERS_W-1:0]    layers;
    logic [COUNT_BITS-1:0]  first_max;
    logic [COUNT_BITS-1:0]  second_max;

    logic                   in_take;
    logic                   hit_ok;
    logic                   walk_done;
    logic                   out_free;
    logic                   load_out;
    logic [PROD_W-1:0]      hits_scaled;
    logic [PROD_W-1:0]      cut_scaled;
    logic [TOTAL_W-1:0]     mip_total_inc;
    logic [TOTAL_W-1:0]     shower_total_inc;

    lhec_hist u_hist (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (hist_ctrl),
        .rd_count   (rd_count),
        .event_hits (event_hits)
    );

    lhec_rank_unit u_rank (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (rank_ctrl),
        .count      (rd_count),
        .layers     (layers),
        .first_max  (first_max),
        .second_max (second_max)
    );

    assign hit_in.ready = (state_reg == ST_IDLE);
    assign in_take      = hit_in.valid && hit_in.ready;
    assign hit_ok       = hit_in.data.hit_present &&
                          (32'(hit_in.data.hit_layer) < 32'(NUM_LAYERS));
    assign walk_done    = (walk_idx_reg == LAYER_IDX_W'(NUM_LAYERS - 1));
    assign out_free     = !out_valid_reg || result_out.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && hit_in.data.last_of_event)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        hist_ctrl          = '0;
        rank_ctrl          = '0;
        load_out           = 1'b0;
        walk_idx_next      = walk_idx_reg;
        hist_ctrl.addr     = LAYER_IDX_W'(hit_in.data.hit_layer);
        unique case (state_reg)
            ST_IDLE:
            begin
                hist_ctrl.inc   = in_take && hit_ok;
                rank_ctrl.clear = in_take && hit_in.data.last_of_event;
                walk_idx_next   = '0;
            end
            ST_WALK:
            begin
                hist_ctrl.addr = walk_idx_reg;
                hist_ctrl.wipe = 1'b1;
                rank_ctrl.step = 1'b1;
                walk_idx_next  = walk_idx_reg + 1'b1;
            end
            ST_DECIDE:
            begin
                hist_ctrl.addr = walk_idx_reg;
            end
            ST_FINISH:
            begin
                hist_ctrl.addr     = walk_idx_reg;
                load_out           = out_free;
                hist_ctrl.hits_clr = out_free;
            end
            default:
            begin
                hist_ctrl.addr = walk_idx_reg;
            end
        endcase
    end

    // density and second max cuts
    assign hits_scaled = PROD_W'(event_hits) << 4;
    assign cut_scaled  = PROD_W'(density_cut_reg) * PROD_W'(layers);

    always_comb
    begin
        mip_next = mip_reg;
        if (state_reg == ST_DECIDE)
        begin
            mip_next = (hits_scaled < cut_scaled) && (second_max < second_max_cut_reg);
        end
    end

    assign mip_total_inc    = mip_total_reg + 1'b1;
    assign shower_total_inc = shower_total_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            walk_idx_reg       <= '0;
            mip_reg            <= 1'b0;
            density_cut_reg    <= DENSITY_CUT_RESET;
            second_max_cut_reg <= SECOND_MAX_CUT_RESET;
            mip_total_reg      <= '0;
            shower_total_reg   <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            walk_idx_reg <= walk_idx_next;
            mip_reg      <= mip_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DENSITY_CUT:    density_cut_reg    <= cfg_data;
                    CFG_SECOND_MAX_CUT: second_max_cut_reg <= cfg_data;
                    default:            ;
                endcase
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (mip_reg)
                begin
                    mip_total_reg <= mip_total_inc;
                end
                else
                begin
                    shower_total_reg <= shower_total_inc;
                end
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result word, no reset needed
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg.is_mip             <= mip_reg;
            out_data_reg.hit_count          <= event_hits;
            out_data_reg.layers_hit         <= layers;
            out_data_reg.first_max          <= first_max;
            out_data_reg.second_max         <= second_max;
            out_data_reg.class_event_number <= mip_reg ? mip_total_inc : shower_total_inc;
        end
    end

    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/lhec_hist.sv
// per-layer hit histogram and event hit counter with saturating increment
`timescale 1ns / 1ps
`default_nettype none

module lhec_hist (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lhec_pkg::hist_ctrl_t            ctrl,
    output logic     [lhec_pkg::COUNT_BITS-1:0]  rd_count,
    output logic     [lhec_pkg::COUNT_BITS-1:0]  event_hits
);
    import lhec_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] counts_reg [NUM_LAYERS];
    logic [COUNT_BITS-1:0] hits_reg;
    logic [COUNT_BITS-1:0] hits_next;
    logic [COUNT_BITS-1:0] count_next;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

    assign rd_count   = counts_reg[ctrl.addr];
    assign event_hits = hits_reg;

    always_comb
    begin
        count_next = rd_count;
        if (ctrl.wipe)
        begin
            count_next = '0;
        end
        else if (ctrl.inc)
        begin
            count_next = sat_inc(rd_count);
        end
    end

    always_comb
    begin
        hits_next = hits_reg;
        if (ctrl.hits_clr)
        begin
            hits_next = '0;
        end
        else if (ctrl.inc)
        begin
            hits_next = sat_inc(hits_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LAYERS; i++)
            begin
                counts_reg[i] <= '0;
            end
            hits_reg <= '0;
        end
        else
        begin
            if (ctrl.inc || ctrl.wipe)
            begin
                counts_reg[ctrl.addr] <= count_next;
            end
            hits_reg <= hits_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/lhec_rank_unit.sv
// shared compare unit: hit layer count and top two layer counts, one layer a step
`timescale 1ns / 1ps
`default_nettype none

module lhec_rank_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire lhec_pkg::rank_ctrl_t            ctrl,
    input  wire logic [lhec_pkg::COUNT_BITS-1:0] count,
    output logic     [lhec_pkg::LAYERS_W-1:0]    layers,
    output logic     [lhec_pkg::COUNT_BITS-1:0]  first_max,
    output logic     [lhec_pkg::COUNT_BITS-1:0]  second_max
);
    import lhec_pkg::*;

    logic [LAYERS_W-1:0]   layers_reg, layers_next;
    logic [COUNT_BITS-1:0] first_reg, first_next;
    logic [COUNT_BITS-1:0] second_reg, second_next;

    always_comb
    begin
        layers_next = layers_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (ctrl.clear)
        begin
            layers_next = '0;
            first_next  = '0;
            second_next = '0;
        end
        else if (ctrl.step && (count != '0))
        begin
            layers_next = layers_reg + 1'b1;
            if (count > first_reg)
            begin
                second_next = first_reg;
                first_next  = count;
            end
            else if (count > second_reg)
            begin
                second_next = count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layers_reg <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end
        else
        begin
            layers_reg <= layers_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign layers     = layers_reg;
    assign first_max  = first_reg;
    assign second_max = second_reg;

endmodule

`default_nettype wire

// File: dv/tb_layer_hit_event_classifier_core.sv
// testbench: layer hit event classifier core, hit words in, one checked result word per event
`timescale 1ns / 1ps

module tb_layer_hit_event_classifier_core;
    import lhec_pkg::*;

    localparam int     ITEMS_PER_PHASE = 210;
    localparam int     N_PHASES        = 8;
    localparam int     PRESSURE_PHASE  = 3;
    localparam int     LONG_HOLD       = 400;
    localparam int     DRAIN_LIMIT     = 20000;
    localparam int     SHOWN_MAX       = 10;
    localparam int     DIR_ROWS        = 16;
    localparam longint LIMIT_NS        = 20_000_000;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct {
        hit_word_t    word;
        bit           typed;
        result_word_t verdict;
    } dir_row_t;

    // typed rows hold the verdict under the reset cuts, the rest come from the predictor
    dir_row_t dir_table [DIR_ROWS] = '{
        // empty event
        '{'{4'd0, 1'b0, 1'b1}, 1'b1, '{1'b0, 12'd0, 5'd0, 12'd0, 12'd0, 32'd1}},
        // hit on the closing word, top layer
        '{'{4'd15, 1'b1, 1'b1}, 1'b1, '{1'b1, 12'd1, 5'd1, 12'd1, 12'd0, 32'd1}},
        '{'{4'd0, 1'b1, 1'b0}, 1'b0, '0},
        '{'{4'd0, 1'b0, 1'b1}, 1'b1, '{1'b1, 12'd1, 5'd1, 12'd1, 12'd0, 32'd2}},
        '{'{4'd15, 1'b0, 1'b0}, 1'b0, '0},
        // equal counts in two layers
        '{'{4'd3, 1'b1, 1'b0}, 1'b0, '0},
        '{'{4'd3, 1'b1, 1'b0}, 1'b0, '0},
        '{'{4'd7, 1'b1, 1'b0}, 1'b0, '0},
        '{'{4'd7, 1'b1, 1'b1}, 1'b0, '0},
        '{'{4'd5, 1'b1, 1'b0}, 1'b0, '0},
        '{'{4'd5, 1'b1, 1'b0}, 1'b0, '0},
        '{'{4'd5, 1'b1, 1'b0}, 1'b0, '0},
        '{'{4'd5, 1'b1, 1'b1}, 1'b0, '0},
        // density exactly at the cut
        '{'{4'd9, 1'b1, 1'b0}, 1'b0, '0},
        '{'{4'd9, 1'b1, 1'b0}, 1'b0, '0},
        '{'{4'd9, 1'b1, 1'b1}, 1'b0, '0}
    };

    logic [CFG_W-1:0] dens_plan [N_PHASES] = '{12'd48, 12'd4095, 12'd0, 12'd20, 12'd64,
                                               12'd4095, 12'd0, 12'd48};
    logic [CFG_W-1:0] sec_plan  [N_PHASES] = '{12'd10, 12'd4095, 12'd0, 12'd3, 12'd12,
                                               12'd0, 12'd0, 12'd10};
    int tx_plan [N_PHASES] = '{15, 35, 0, 10, 40, 15, 25, 0};
    int rx_plan [N_PHASES] = '{15, 10, 30, 0, 40, 25, 15, 0};

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    lhec_hit_if    hit_ch ();
    lhec_result_if res_ch ();

    layer_hit_event_classifier_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .hit_in     (hit_ch),
        .result_out (res_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // predictor state
    logic [COUNT_BITS-1:0] layer_tally [NUM_LAYERS];
    logic [COUNT_BITS-1:0] event_tally;
    logic [TOTAL_W-1:0]    mip_tally;
    logic [TOTAL_W-1:0]    shower_tally;
    logic [CFG_W-1:0]      density_cut_m;
    logic [CFG_W-1:0]      second_cut_m;

    result_word_t verdict_q [$];

    int  tx_gap_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_req = 1'b0;
    int  words_sent = 0;
    int  results_seen = 0;
    int  mismatch_cnt = 0;
    int  lost_cnt = 0;

    function automatic bit classify_word(input hit_word_t w, output result_word_t verdict);
        logic [COUNT_BITS-1:0] top;
        logic [COUNT_BITS-1:0] runner_up;
        logic [COUNT_BITS-1:0] c;
        int unsigned           n_layers;
        int unsigned           lhs;
        int unsigned           rhs;
        int                    k;
        bit                    mip;
        verdict = '0;
        if (w.hit_present && int'(w.hit_layer) < NUM_LAYERS)
        begin
            if (layer_tally[w.hit_layer] != COUNT_MAX)
                layer_tally[w.hit_layer] = layer_tally[w.hit_layer] + 1'b1;
            if (event_tally != COUNT_MAX)
                event_tally = event_tally + 1'b1;
        end
        if (!w.last_of_event)
            return 1'b0;
        top = '0;
        runner_up = '0;
        n_layers = 0;
        for (k = 0; k < NUM_LAYERS; k++)
        begin
            c = layer_tally[k];
            if (c != '0)
            begin
                n_layers++;
                if (c > top)
                begin
                    runner_up = top;
                    top = c;
                end
                else if (c > runner_up)
                    runner_up = c;
            end
            layer_tally[k] = '0;
        end
        lhs = 32'(event_tally) * 32'd16;
        rhs = 32'(density_cut_m) * n_layers;
        mip = (lhs < rhs) && (runner_up < second_cut_m);
        if (mip)
        begin
            mip_tally = mip_tally + 1'b1;
            verdict.class_event_number = mip_tally;
        end
        else
        begin
            shower_tally = shower_tally + 1'b1;
            verdict.class_event_number = shower_tally;
        end
        verdict.is_mip     = mip;
        verdict.hit_count  = event_tally;
        verdict.layers_hit = LAYERS_W'(n_layers);
        verdict.first_max  = top;
        verdict.second_max = runner_up;
        event_tally = '0;
        return 1'b1;
    endfunction

    task automatic send_word(input hit_word_t w, input bit typed, input result_word_t typed_res);
        result_word_t verdict;
        if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct)
        begin
            hit_ch.valid <= 1'b0;
            repeat ($urandom_range(14, 1)) @(posedge clk);
        end
        hit_ch.valid <= 1'b1;
        hit_ch.data  <= w;
        @(posedge clk);
        while (!hit_ch.ready)
            @(posedge clk);
        words_sent++;
        if (classify_word(w, verdict))
            verdict_q.insert(verdict_q.size(), typed ? typed_res : verdict);
    endtask

    // one event: track-like, shower-like, loose noise or empty
    task automatic send_event(output int n_words);
        hit_word_t w;
        int        style;
        int        n_hits;
        int        k;
        int        cursor;
        int        spot;
        bit        closing_hit;
        style = $urandom_range(99);
        cursor = $urandom_range(NUM_LAYERS - 1);
        n_words = 0;
        if (style < 10)
            n_hits = 0;
        else if (style < 50)
            n_hits = $urandom_range(16, 1);
        else if (style < 80)
            n_hits = $urandom_range(40, 4);
        else
            n_hits = $urandom_range(12, 1);
        closing_hit = (n_hits != 0) && ($urandom_range(1) == 1);
        for (k = 0; k < n_hits; k++)
        begin
            w.hit_present   = ($urandom_range(19) != 0);
            w.last_of_event = closing_hit && (k == n_hits - 1);
            if (style < 50)
            begin
                if (k != 0 && $urandom_range(5) != 0)
                    cursor = (cursor + 1) % NUM_LAYERS;
                w.hit_layer = LAYER_W'(cursor);
            end
            else if (style < 80)
            begin
                spot = cursor + int'($urandom_range(4)) - 2;
                if (spot < 0)
                    spot = 0;
                if (spot > NUM_LAYERS - 1)
                    spot = NUM_LAYERS - 1;
                w.hit_layer = LAYER_W'(spot);
            end
            else
            begin
                w.hit_layer   = LAYER_W'($urandom_range(15));
                w.hit_present = 1'($urandom_range(1));
            end
            send_word(w, 1'b0, '0);
            n_words++;
        end
        if (!closing_hit)
        begin
            w.hit_layer     = LAYER_W'($urandom_range(15));
            w.hit_present   = 1'b0;
            w.last_of_event = 1'b1;
            send_word(w, 1'b0, '0);
            n_words++;
        end
    endtask

    task automatic wait_all_results();
        hit_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (verdict_q.size() != 0);
    endtask

    task automatic set_cuts(input logic [CFG_W-1:0] dens, input logic [CFG_W-1:0] sec);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DENSITY_CUT;
        cfg_data  <= dens;
        @(posedge clk);
        cfg_index <= CFG_SECOND_MAX_CUT;
        cfg_data  <= sec;
        @(posedge clk);
        cfg_we <= 1'b0;
        density_cut_m = dens;
        second_cut_m  = sec;
    endtask

    task automatic compare_verdict(input result_word_t want, input result_word_t got);
        string bad;
        bad = "";
        if (got.is_mip != want.is_mip)
            bad = {bad, " is_mip"};
        if (got.hit_count != want.hit_count)
            bad = {bad, " hit_count"};
        if (got.layers_hit != want.layers_hit)
            bad = {bad, " layers_hit"};
        if (got.first_max != want.first_max)
            bad = {bad, " first_max"};
        if (got.second_max != want.second_max)
            bad = {bad, " second_max"};
        if (got.class_event_number != want.class_event_number)
            bad = {bad, " class_event_number"};
        if (bad != "")
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= SHOWN_MAX)
            begin
                $display("result %0d wrong in%s", results_seen, bad);
                $display("  expected mip=%0d hits=%0d layers=%0d max=%0d/%0d num=%0d",
                         want.is_mip, want.hit_count, want.layers_hit,
                         want.first_max, want.second_max, want.class_event_number);
                $display("  got      mip=%0d hits=%0d layers=%0d max=%0d/%0d num=%0d",
                         got.is_mip, got.hit_count, got.layers_hit, got.first_max,
                         got.second_max, got.class_event_number);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("timeout with %0d results outstanding", verdict_q.size());
        $display("Test completed with failures");
        $finish;
    end

    // output side: random stalls plus one long hold-off on request
    initial
    begin : result_sink
        int hold_cnt;
        forever
        begin
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < LONG_HOLD; hold_cnt++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(14, 1)) @(posedge clk);
            end
            else
            begin
                res_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_word_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (verdict_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= SHOWN_MAX)
                    $display("result %0d arrived with none pending: mip=%0d hits=%0d num=%0d",
                             results_seen, res_ch.data.is_mip, res_ch.data.hit_count,
                             res_ch.data.class_event_number);
            end
            else
            begin
                want = verdict_q.pop_front();
                compare_verdict(want, res_ch.data);
            end
        end
    end

    initial
    begin : stimulus
        int        p;
        int        k;
        int        n;
        int        phase_words;
        int        wait_cycles;
        bit        hold_done;
        bit        pause_done;

        rst_n        <= 1'b0;
        hit_ch.valid <= 1'b0;
        hit_ch.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_DENSITY_CUT;
        cfg_data     <= '0;
        for (k = 0; k < NUM_LAYERS; k++)
            layer_tally[k] = '0;
        event_tally   = '0;
        mip_tally     = '0;
        shower_tally  = '0;
        density_cut_m = DENSITY_CUT_RESET;
        second_cut_m  = SECOND_MAX_CUT_RESET;
        hold_done     = 1'b0;
        pause_done    = 1'b0;

        dens_plan[5] = CFG_W'($urandom_range(4095));
        sec_plan[5]  = CFG_W'($urandom_range(4095));
        dens_plan[6] = CFG_W'($urandom_range(96, 16));
        sec_plan[6]  = CFG_W'($urandom_range(16, 1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (p = 0; p < N_PHASES; p++)
        begin
            if (p != 0)
            begin
                wait_all_results();
                repeat (NUM_LAYERS + 4) @(posedge clk);
                set_cuts(dens_plan[p], sec_plan[p]);
            end
            tx_gap_pct  = tx_plan[p];
            rx_idle_pct = rx_plan[p];

            if (p == 0)
                for (k = 0; k < DIR_ROWS; k++)
                    send_word(dir_table[k].word, dir_table[k].typed, dir_table[k].verdict);

            phase_words = 0;
            while (phase_words < ITEMS_PER_PHASE)
            begin
                if (p == PRESSURE_PHASE && !hold_done && phase_words >= 40)
                begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                if (p == PRESSURE_PHASE && !pause_done && phase_words >= 150)
                begin
                    wait_all_results();
                    pause_done = 1'b1;
                end
                send_event(n);
                phase_words += n;
            end
        end

        hit_ch.valid <= 1'b0;
        wait_cycles = 0;
        do
        begin
            @(posedge clk);
            wait_cycles++;
        end
        while (verdict_q.size() != 0 && wait_cycles < DRAIN_LIMIT);
        repeat (NUM_LAYERS + 4) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            lost_cnt = verdict_q.size();
            $display("%0d results never arrived", lost_cnt);
        end
        if (mismatch_cnt > SHOWN_MAX)
            $display("%0d bad results in all, first %0d shown", mismatch_cnt, SHOWN_MAX);

        $display("ran %0d hit words through %0d events (%0d mip, %0d shower), %0d checked",
                 words_sent, mip_tally + shower_tally, mip_tally, shower_tally, results_seen);
        $display("covered %0d cut settings incl. both extremes and a long output stall",
                 N_PHASES);
        if (mismatch_cnt == 0 && lost_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
